[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with reset disable.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tsz_pkg.sv]
// ----------------------------------------------------------------------------
// tsz_pkg
// Shared types and constants for the zero-sum triplet finder.
// ----------------------------------------------------------------------------
package tsz_pkg;

    localparam int MAX_N_DEFAULT = 32;
    localparam int DATA_W = 32;
    localparam int SUM_W = 34;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_FETCH  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RD,      // read store[b-1]
        ST_SORT_CMP,     // compare with key, shift or place
        ST_SORT_KEY,     // read store[a] as key
        ST_SORT_KEYW,
        ST_SRCH,         // decide next action
        ST_RD_WAIT,      // waiting on data read
        ST_EVAL,
        ST_SKIP_RD,
        ST_SKIP_EV,
        ST_OUT
    } state_t;

    // sub-phase: outer check, pair evaluation, low or high duplicate skip
    typedef enum logic [1:0] { PH_OUTER, PH_PAIR, PH_SKIPLO, PH_SKIPHI } phase_t;

    // command from controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic [2:0] rd_sel;  // which read plan
        logic wr_shift;      // store[b] = store[b-1]
        logic wr_key;        // store[b] = key
        logic ld_key;        // latch key from read data
        logic sort_init;
        logic sort_next_a;
        logic sort_dec_b;
        logic search_init;
        logic step;          // apply evaluation result
        logic skip_step;
        logic finish;        // search done
        logic res_trip;
        logic res_exh;
        logic res_plain;
        logic res_drop;
    } cmd_dp_t;

    localparam logic [2:0] RD_SORT_PREV = 3'd0;
    localparam logic [2:0] RD_SORT_KEY  = 3'd1;
    localparam logic [2:0] RD_IJK       = 3'd2;
    localparam logic [2:0] RD_SKIP      = 3'd3;
    localparam logic [2:0] RD_OUTER     = 3'd4;   // store[i] and store[i-1]

    typedef struct packed {
        logic full;
        logic sorted;
        logic done;
        logic empty;
        logic sort_a_end;    // a >= count
        logic sort_b_zero;
        logic sort_gt;       // store[b-1] > key
        logic outer_end;     // i >= n
        logic outer_dup;     // i>0 and store[i]==store[i-1]
        logic pair_ok;       // low < high < n
        logic sum_neg;
        logic sum_pos;
        logic skip_more;     // still skipping duplicates
    } sts_dp_t;

endpackage

[rtl/tsz_if.sv]
// ----------------------------------------------------------------------------
// tsz_in_if / tsz_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface tsz_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic signed [31:0] value;
    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface tsz_out_if;
    logic        valid;
    logic        ready;
    logic        triplet_valid;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
    logic        exhausted;
    logic        append_dropped;
    modport source (output valid, triplet_valid, first_value, second_value, third_value,
                    exhausted, append_dropped, input ready);
    modport sink   (input valid, triplet_valid, first_value, second_value, third_value,
                    exhausted, append_dropped, output ready);
endinterface

[rtl/tsz_ram.sv]
// ----------------------------------------------------------------------------
// tsz_ram
// Generic RAM, one write port, two read ports, registered read.
// ----------------------------------------------------------------------------
module tsz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

[rtl/tsz_datapath.sv]
// ----------------------------------------------------------------------------
// tsz_datapath
// Element store, cursors, sort and search arithmetic, result register.
// ----------------------------------------------------------------------------
module tsz_datapath
    import tsz_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic signed [DATA_W-1:0] value,
    input  cmd_dp_t       cmd,
    output sts_dp_t       sts,
    output logic          res_trip,
    output logic signed [DATA_W-1:0] res_first,
    output logic signed [DATA_W-1:0] res_second,
    output logic signed [DATA_W-1:0] res_third,
    output logic          res_exh,
    output logic          res_drop
);
    localparam int AW = $clog2(MAX_N);
    localparam int CW = $clog2(MAX_N + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          sorted_reg, sorted_next;
    logic          done_reg, done_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0] a_reg, a_next, b_reg, b_next;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] vi_reg;
    logic          skip_low_reg, skip_low_next;

    logic          we;
    logic [AW-1:0] waddr, ra, rb;
    logic [DATA_W-1:0] wdata, rda, rdb;

    tsz_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
    );

    // read address plan
    always_comb
    begin
        ra = '0;
        rb = '0;
        unique case (cmd.rd_sel)
            RD_SORT_PREV: begin ra = AW'(b_reg - CW'(1)); rb = '0; end
            RD_SORT_KEY:  begin ra = a_reg[AW-1:0];       rb = '0; end
            RD_IJK:       begin ra = j_reg[AW-1:0];       rb = k_reg[AW-1:0]; end
            RD_SKIP:
            begin
                ra = j_reg[AW-1:0];
                rb = AW'(j_reg - CW'(1));
                if (!skip_low_reg)
                begin
                    ra = k_reg[AW-1:0];
                    rb = AW'(k_reg + CW'(1));
                end
            end
            RD_OUTER:
            begin
                // outer element and its left neighbor
                ra = i_reg[AW-1:0];
                rb = AW'(i_reg - CW'(1));
            end
            default: ;
        endcase
    end

    // writes
    always_comb
    begin
        we    = 1'b0;
        waddr = b_reg[AW-1:0];
        wdata = key_reg;
        if (cmd.append && count_reg != CW'(MAX_N))
        begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = value;
        end
        else if (cmd.wr_shift)
        begin
            we    = 1'b1;
            wdata = rda;
        end
        else if (cmd.wr_key)
        begin
            we = 1'b1;
        end
    end

    logic signed [SUM_W-1:0] sum;
    assign sum = SUM_W'(vi_reg) + SUM_W'($signed(rda)) + SUM_W'($signed(rdb));

    always_comb
    begin
        sts.full        = (count_reg == CW'(MAX_N));
        sts.sorted      = sorted_reg;
        sts.done        = done_reg;
        sts.empty       = (count_reg == '0);
        sts.sort_a_end  = (a_reg >= count_reg);
        sts.sort_b_zero = (b_reg == '0);
        sts.sort_gt     = ($signed(rda) > key_reg);
        sts.outer_end   = (i_reg >= count_reg);
        sts.outer_dup   = (i_reg != '0) && (rda == rdb);
        sts.pair_ok     = (j_reg < k_reg) && (k_reg < count_reg);
        sts.sum_neg     = sum < 0;
        sts.sum_pos     = sum > 0;
        sts.skip_more   = (j_reg < k_reg) && (rda == rdb);
    end

    always_comb
    begin
        count_next    = count_reg;
        sorted_next   = sorted_reg;
        done_next     = done_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        skip_low_next = skip_low_reg;
        if (cmd.clear)
        begin
            count_next  = '0;
            sorted_next = 1'b0;
            done_next   = 1'b0;
        end
        if (cmd.append && !sts.full)
        begin
            count_next  = count_reg + CW'(1);
            sorted_next = 1'b0;
            done_next   = 1'b0;
        end
        if (cmd.sort_init)
        begin
            a_next = CW'(1);
            b_next = CW'(1);
        end
        if (cmd.sort_next_a)
        begin
            a_next = a_reg + CW'(1);
            b_next = a_reg + CW'(1);
        end
        if (cmd.sort_dec_b)
        begin
            b_next = b_reg - CW'(1);
        end
        if (cmd.search_init)
        begin
            sorted_next = 1'b1;
            done_next   = sts.empty;
            i_next      = '0;
            j_next      = CW'(1);
            k_next      = count_reg - CW'(1);
        end
        if (cmd.step && cmd.rd_sel != RD_OUTER)
        begin
            // pair step; an outer step only latches the outer value
            if (sts.sum_neg)
            begin
                j_next = j_reg + CW'(1);
            end
            else if (sts.sum_pos)
            begin
                k_next = k_reg - CW'(1);
            end
            else
            begin
                j_next        = j_reg + CW'(1);
                k_next        = k_reg - CW'(1);
                skip_low_next = 1'b1;
            end
        end
        if (cmd.rd_sel == RD_OUTER && cmd.skip_step)
        begin
            // advance outer cursor
            i_next = i_reg + CW'(1);
            j_next = i_reg + CW'(2);
            k_next = count_reg - CW'(1);
        end
        else if (cmd.skip_step)
        begin
            if (skip_low_reg)
            begin
                if (sts.skip_more)
                    j_next = j_reg + CW'(1);
                else
                    skip_low_next = 1'b0;
            end
            else if ((j_reg < k_reg) && (rda == rdb))
            begin
                k_next = k_reg - CW'(1);
            end
        end
        if (cmd.finish)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sorted_reg   <= 1'b0;
            done_reg     <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            skip_low_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            sorted_reg   <= sorted_next;
            done_reg     <= done_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            skip_low_reg <= skip_low_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_key)
            key_reg <= rda;
        if (cmd.rd_sel == RD_OUTER && cmd.step)
            vi_reg <= rda;
        if (cmd.res_trip)
        begin
            res_first  <= vi_reg;
            res_second <= rda;
            res_third  <= rdb;
        end
        else if (cmd.res_exh || cmd.res_plain || cmd.res_drop)
        begin
            res_first  <= '0;
            res_second <= '0;
            res_third  <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_trip <= 1'b0;
            res_exh  <= 1'b0;
            res_drop <= 1'b0;
        end
        else if (cmd.res_trip || cmd.res_exh || cmd.res_plain || cmd.res_drop)
        begin
            res_trip <= cmd.res_trip;
            res_exh  <= cmd.res_exh;
            res_drop <= cmd.res_drop;
        end
    end
endmodule

[rtl/tsz_ctrl.sv]
// ----------------------------------------------------------------------------
// tsz_ctrl
// Sequencer for load, insertion sort and two-pointer search.
// ----------------------------------------------------------------------------
module tsz_ctrl
    import tsz_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic [1:0] in_command,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  sts_dp_t sts,
    output cmd_dp_t cmd
);
    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    logic   ovalid_reg, ovalid_next;

    logic accept;
    assign in_ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_command == CMD_FETCH)
                begin
                    // every fetch starts its search in the outer-element phase
                    ph_next = PH_OUTER;
                    if (!sts.sorted)
                        state_next = ST_SORT_KEY;
                    else
                        state_next = ST_SRCH;
                end
            end
            ST_SORT_KEY:
                state_next = sts.sort_a_end ? ST_SRCH : ST_SORT_KEYW;
            ST_SORT_KEYW: state_next = ST_SORT_RD;
            ST_SORT_RD:   state_next = ST_SORT_CMP;
            ST_SORT_CMP:
            begin
                if (!sts.sort_b_zero && sts.sort_gt)
                    state_next = ST_SORT_RD;
                else
                    state_next = ST_SORT_KEY;
            end
            ST_SRCH:
            begin
                if (sts.done)
                    state_next = ST_OUT;
                else if (ph_reg == PH_OUTER && sts.outer_end)
                    state_next = ST_OUT;
                else
                    state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: state_next = ST_EVAL;
            ST_EVAL:
            begin
                state_next = ST_SRCH;
                unique case (ph_reg)
                    PH_OUTER: ph_next = sts.outer_dup ? PH_OUTER : PH_PAIR;
                    PH_PAIR:
                    begin
                        if (!sts.pair_ok)
                            ph_next = PH_OUTER;
                        else if (!sts.sum_neg && !sts.sum_pos)
                        begin
                            ph_next    = PH_SKIPLO;
                            state_next = ST_SKIP_RD;
                        end
                    end
                    default: ph_next = ph_reg;
                endcase
            end
            ST_SKIP_RD: state_next = ST_SKIP_EV;
            ST_SKIP_EV:
            begin
                if (!sts.skip_more)
                begin
                    if (ph_reg == PH_SKIPLO)
                    begin
                        ph_next    = PH_SKIPHI;
                        state_next = ST_SKIP_RD;
                    end
                    else
                    begin
                        ph_next    = PH_PAIR;
                        state_next = ST_IDLE;
                    end
                end
                else
                    state_next = ST_SKIP_RD;
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.rd_sel  = RD_IJK;
        ovalid_next = ovalid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_command)
                        CMD_CLEAR:  begin cmd.clear = 1'b1; cmd.res_plain = 1'b1; end
                        CMD_APPEND:
                        begin
                            cmd.append = 1'b1;
                            cmd.res_plain = !sts.full;
                            cmd.res_drop  = sts.full;
                        end
                        CMD_FETCH:  cmd.sort_init = !sts.sorted;
                        default: ;
                    endcase
                    if (in_command == CMD_CLEAR || in_command == CMD_APPEND)
                        ovalid_next = 1'b1;
                end
            end
            ST_SORT_KEY:
            begin
                cmd.rd_sel = RD_SORT_KEY;
                if (sts.sort_a_end)
                    cmd.search_init = 1'b1;
            end
            ST_SORT_KEYW:
            begin
                cmd.rd_sel = RD_SORT_PREV;
                cmd.ld_key = 1'b1;
            end
            ST_SORT_RD: cmd.rd_sel = RD_SORT_PREV;
            ST_SORT_CMP:
            begin
                cmd.rd_sel = RD_SORT_KEY;
                if (!sts.sort_b_zero && sts.sort_gt)
                begin
                    cmd.wr_shift   = 1'b1;
                    cmd.sort_dec_b = 1'b1;
                    cmd.rd_sel     = RD_SORT_PREV;
                end
                else
                begin
                    cmd.wr_key      = 1'b1;
                    cmd.sort_next_a = 1'b1;
                end
            end
            ST_SRCH:
            begin
                cmd.rd_sel = (ph_reg == PH_OUTER) ? RD_OUTER : RD_IJK;
                if (sts.done)
                    cmd.res_exh = 1'b1;
                else if (ph_reg == PH_OUTER && sts.outer_end)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_exh = 1'b1;
                end
            end
            ST_RD_WAIT: cmd.rd_sel = (ph_reg == PH_OUTER) ? RD_OUTER : RD_IJK;
            ST_EVAL:
            begin
                if (ph_reg == PH_OUTER)
                begin
                    cmd.rd_sel = RD_OUTER;
                    if (sts.outer_dup)
                        cmd.skip_step = 1'b1;
                    else
                        cmd.step = 1'b1;   // latch outer value
                end
                else if (!sts.pair_ok)
                begin
                    cmd.rd_sel    = RD_OUTER;
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (!sts.sum_neg && !sts.sum_pos)
                        cmd.res_trip = 1'b1;
                end
            end
            ST_SKIP_RD: cmd.rd_sel = RD_SKIP;
            ST_SKIP_EV:
            begin
                cmd.rd_sel    = RD_SKIP;
                cmd.skip_step = 1'b1;
                if (!sts.skip_more && ph_reg == PH_SKIPHI)
                    ovalid_next = 1'b1;
            end
            ST_OUT: ovalid_next = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ph_reg     <= PH_OUTER;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ph_reg     <= ph_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

[rtl/three_sum_zero_triplets_top.sv]
// ----------------------------------------------------------------------------
// three_sum_zero_triplets_top
// Zero-sum triplet finder: load, sort on first fetch, two-pointer search.
// ----------------------------------------------------------------------------
// channel  | dir | word
// in_ch    | in  | command, value
// out_ch   | out | triplet_valid, first/second/third_value, exhausted,
//          |     | append_dropped
//
// Clear and append: result word valid the cycle after the input word is taken.
// Fetch on an unsorted set sorts first: key read, key wait, read and compare per
// key, read and compare per element moved. Search: decide, read wait, evaluate
// per outer check or pointer step; skip read and evaluate per duplicate probe
// after a hit. A resumed fetch rechecks the outer element. Input stalls until
// the result word is taken. Reset clears count and search state, not the store.
module three_sum_zero_triplets_top
    import tsz_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    tsz_in_if.sink     in_ch,
    tsz_out_if.source  out_ch
);
    cmd_dp_t cmd;
    sts_dp_t sts;

    tsz_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_command(in_ch.command), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts(sts), .cmd(cmd)
    );

    tsz_datapath #(.MAX_N(MAX_N)) u_dp (
        .clk(clk), .rst_n(rst_n), .value(in_ch.value),
        .cmd(cmd), .sts(sts),
        .res_trip(out_ch.triplet_valid),
        .res_first(out_ch.first_value),
        .res_second(out_ch.second_value),
        .res_third(out_ch.third_value),
        .res_exh(out_ch.exhausted),
        .res_drop(out_ch.append_dropped)
    );
endmodule

[rtl/tsz_checker.sv]
// ----------------------------------------------------------------------------
// tsz_checker
// Port-level checks on the triplet finder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsz_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic trip,
    input logic exh,
    input logic drop
);
    `CHK_ASSERT(a_one_flag, clk, rst_n, out_valid |-> !(trip && exh), "triplet and exhausted")
    `CHK_ASSERT(a_no_accept_busy, clk, rst_n, out_valid |-> !in_ready, "input taken while busy")
    `CHK_ASSERT(a_drop_alone, clk, rst_n, (out_valid && drop) |-> !trip && !exh, "drop mixed")
    `CHK_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule

bind three_sum_zero_triplets_top tsz_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .trip(out_ch.triplet_valid), .exh(out_ch.exhausted), .drop(out_ch.append_dropped)
);
